// ===== design/dual_stack_shared_array_unit_defines.svh =====
// Assertion macros shared by the dual stack unit.
`ifndef DUAL_STACK_SHARED_ARRAY_UNIT_DEFINES_SVH
`define DUAL_STACK_SHARED_ARRAY_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dsa_pkg.sv =====
package dsa_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int ACTION_W      = 3;
   localparam int STATUS_W      = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_A = 3'd0,
      ACT_PUSH_B = 3'd1,
      ACT_POP_A  = 3'd2,
      ACT_POP_B  = 3'd3,
      ACT_LIST_A = 3'd4,
      ACT_LIST_B = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

endpackage

// ===== design/dsa_req_if.sv =====
interface dsa_req_if import dsa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [DATA_W-1:0]   push_value;

   modport source (output valid, action, push_value, input ready);
   modport sink (input valid, action, push_value, output ready);
endinterface

// ===== design/dsa_rsp_if.sv =====
interface dsa_rsp_if import dsa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   data_value;
   logic [STATUS_W-1:0]        status;
   logic                       last;

   modport source (output valid, data_value, status, last, input ready);
   modport sink (input valid, data_value, status, last, output ready);
endinterface

// ===== design/dual_stack_shared_array_unit.sv =====
// Push and any refused or empty request give their word from the output register after acceptance;
// a pop passes through the registered store read and then the output register.
// A pop or list takes no new request until its last word is registered; a list of N entries gives N words,
// one word per cycle while the output register is free, after the first read of the single store read port.
// Reset (synchronous, active high) clears both stack counts, the sequencer and the output
// valid; store contents stay undefined until written.
`include "dual_stack_shared_array_unit_defines.svh"

module dual_stack_shared_array_unit import dsa_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   dsa_req_if.sink    req_bus,
   dsa_rsp_if.source  rsp_bus
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Sequencer: IDLE takes requests, FETCH drains words read from the store.
   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_FETCH = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_a_ff, count_a_in;
   logic [CNT_W-1:0]          count_b_ff, count_b_in;
   logic [IDX_W-1:0]          walk_addr_ff, walk_addr_in;
   logic [CNT_W-1:0]          walk_left_ff, walk_left_in;
   logic                      walk_up_ff, walk_up_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Shared store: one write port, one registered read port.
   logic signed [DATA_W-1:0]  store_mem [DEPTH];
   logic signed [DATA_W-1:0]  rd_data_ff;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;

   logic                      req_fire;
   logic                      out_free;
   logic                      full;
   logic [CNT_W-1:0]          a_top_pos;
   logic [CNT_W-1:0]          b_top_pos;
   logic [CNT_W-1:0]          b_push_pos;
   logic [IDX_W-1:0]          walk_next;

   // The output register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire = req_bus.valid && req_bus.ready;

   assign full = ({1'b0, count_a_ff} + {1'b0, count_b_ff}) >= (CNT_W + 1)'(DEPTH);

   // Top of A sits one below its count; top of B sits at DEPTH minus its count.
   assign a_top_pos  = count_a_ff - CNT_W'(1);
   assign b_top_pos  = CNT_W'(DEPTH) - count_b_ff;
   assign b_push_pos = CNT_W'(DEPTH) - count_b_ff - CNT_W'(1);

   // List A walks down toward entry 0, list B walks up toward the top entry.
   assign walk_next = walk_up_ff ? walk_addr_ff + IDX_W'(1) : walk_addr_ff - IDX_W'(1);

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.data_value = rsp_data_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.last       = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      walk_addr_in  = walk_addr_ff;
      walk_left_in  = walk_left_ff;
      walk_up_in    = walk_up_ff;
      // Drop the held word once the sink takes it.
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = count_a_ff[IDX_W-1:0];
      rd_en         = 1'b0;
      rd_addr       = walk_addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.action) inside
                  ACT_PUSH_A, ACT_PUSH_B: begin
                     // Push answers at once: ok or overflow.
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_last_in   = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_OVERFLOW;
                     end else begin
                        rsp_status_in = ST_OK;
                        wr_en         = 1'b1;
                        if (req_bus.action == ACT_PUSH_A) begin
                           wr_addr    = count_a_ff[IDX_W-1:0];
                           count_a_in = count_a_ff + CNT_W'(1);
                        end else begin
                           wr_addr    = b_push_pos[IDX_W-1:0];
                           count_b_in = count_b_ff + CNT_W'(1);
                        end
                     end
                  end
                  ACT_POP_A, ACT_LIST_A: begin
                     if (count_a_ff == '0) begin
                        // Empty stack: one word, underflow for pop, empty for list.
                        rsp_valid_in  = 1'b1;
                        rsp_data_in   = '0;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = (req_bus.action == ACT_POP_A) ? ST_UNDERFLOW : ST_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = a_top_pos[IDX_W-1:0];
                        walk_addr_in = a_top_pos[IDX_W-1:0];
                        walk_up_in   = 1'b0;
                        state_in     = S_FETCH;
                        if (req_bus.action == ACT_POP_A) begin
                           walk_left_in = CNT_W'(1);
                           count_a_in   = a_top_pos;
                        end else begin
                           walk_left_in = count_a_ff;
                        end
                     end
                  end
                  ACT_POP_B, ACT_LIST_B: begin
                     if (count_b_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_data_in   = '0;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = (req_bus.action == ACT_POP_B) ? ST_UNDERFLOW : ST_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = b_top_pos[IDX_W-1:0];
                        walk_addr_in = b_top_pos[IDX_W-1:0];
                        walk_up_in   = 1'b1;
                        state_in     = S_FETCH;
                        if (req_bus.action == ACT_POP_B) begin
                           walk_left_in = CNT_W'(1);
                           count_b_in   = count_b_ff - CNT_W'(1);
                        end else begin
                           walk_left_in = count_b_ff;
                        end
                     end
                  end
                  default: begin
                     // Unused action codes: take the word and drop it.
                  end
               endcase
            end
         end
         S_FETCH: begin
            // Read data is valid here and holds until the output register frees up.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = rd_data_ff;
               rsp_status_in = ST_OK;
               rsp_last_in   = (walk_left_ff == CNT_W'(1));
               walk_left_in  = walk_left_ff - CNT_W'(1);
               if (walk_left_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  // Advance and issue the next read in the same cycle.
                  rd_en        = 1'b1;
                  rd_addr      = walk_next;
                  walk_addr_in = walk_next;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Store: writes only in IDLE, reads only when entering or inside FETCH,
   // so a read and a write never meet in one cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req_bus.push_value;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      walk_addr_ff  <= walk_addr_in;
      walk_left_ff  <= walk_left_in;
      walk_up_ff    <= walk_up_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The two stacks never claim more entries than the store holds.
   `DSA_ASSERT_NOW(a_counts_fit, clock, reset, 1'b1, ({1'b0, count_a_ff} + {1'b0, count_b_ff}) <= (CNT_W + 1)'(DEPTH), "stack counts exceed store depth")
   // A pop from a non-empty stack goes on to fetch from the store.
   `DSA_ASSERT_NEXT(a_pop_fetches, clock, reset, req_fire && ((req_bus.action == ACT_POP_A && count_a_ff != '0) || (req_bus.action == ACT_POP_B && count_b_ff != '0)), state_ff == S_FETCH, "pop did not start a store fetch")
   // The final fetched word ends the walk.
   `DSA_ASSERT_NEXT(a_walk_ends, clock, reset, state_ff == S_FETCH && out_free && walk_left_ff == CNT_W'(1), state_ff == S_IDLE && rsp_valid_ff && rsp_last_ff, "walk did not end on its last word")
   // Any status other than ok carries zero data.
   `DSA_ASSERT_NOW(a_err_zero_data, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_data_ff == '0, "error word carries data")

endmodule

// ===== dv/dsa_stack_checker.sv =====
`timescale 1ns / 1ps

module dsa_stack_checker import dsa_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic signed [DATA_W-1:0]  req_push_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [DATA_W-1:0]  rsp_data_value,
   input  logic [STATUS_W-1:0]       rsp_status,
   input  logic                      rsp_last,
   output int                        error_count,
   output int                        pending_count,
   output int                        words_checked
);

   typedef struct packed {
      logic signed [DATA_W-1:0] data_value;
      status_type               status;
      logic                     last;
   } stack_word_type;

   stack_word_type    expected_words[$];
   logic [DATA_W-1:0] shared_words [DEPTH];
   int unsigned       depth_a = 0;
   int unsigned       depth_b = 0;
   int                errors  = 0;
   int                checked = 0;

   function automatic void expect_word(input logic [DATA_W-1:0] value, input status_type st,
                                       input logic is_last);
      stack_word_type w;
      w.data_value = value;
      w.status     = st;
      w.last       = is_last;
      expected_words.push_back(w);
   endfunction

   // Apply one accepted request to the local copy of both stacks and queue its words.
   function automatic void predict_stack_action(input logic [ACTION_W-1:0] act,
                                                input logic [DATA_W-1:0] value);
      bit full;
      full = (depth_a + depth_b) >= DEPTH;
      case (act)
         ACT_PUSH_A: begin
            if (full) begin
               expect_word('0, ST_OVERFLOW, 1'b1);
            end else begin
               shared_words[depth_a] = value;
               depth_a++;
               expect_word('0, ST_OK, 1'b1);
            end
         end
         ACT_PUSH_B: begin
            if (full) begin
               expect_word('0, ST_OVERFLOW, 1'b1);
            end else begin
               depth_b++;
               shared_words[DEPTH - depth_b] = value;
               expect_word('0, ST_OK, 1'b1);
            end
         end
         ACT_POP_A: begin
            if (depth_a == 0) begin
               expect_word('0, ST_UNDERFLOW, 1'b1);
            end else begin
               depth_a--;
               expect_word(shared_words[depth_a], ST_OK, 1'b1);
            end
         end
         ACT_POP_B: begin
            if (depth_b == 0) begin
               expect_word('0, ST_UNDERFLOW, 1'b1);
            end else begin
               expect_word(shared_words[DEPTH - depth_b], ST_OK, 1'b1);
               depth_b--;
            end
         end
         ACT_LIST_A: begin
            if (depth_a == 0) begin
               expect_word('0, ST_EMPTY, 1'b1);
            end else begin
               for (int unsigned i = 0; i < depth_a; i++)
                  expect_word(shared_words[depth_a - 1 - i], ST_OK, i == depth_a - 1);
            end
         end
         ACT_LIST_B: begin
            if (depth_b == 0) begin
               expect_word('0, ST_EMPTY, 1'b1);
            end else begin
               for (int unsigned i = 0; i < depth_b; i++)
                  expect_word(shared_words[DEPTH - depth_b + i], ST_OK, i == depth_b - 1);
            end
         end
         default: ;  // spare codes: no word, no state change
      endcase
   endfunction

   function automatic void check_field(input string field, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      stack_word_type want;
      if (reset) begin
         expected_words.delete();
         depth_a = 0;
         depth_b = 0;
      end else begin
         if (req_valid && req_ready)
            predict_stack_action(req_action, req_push_value);
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t ns: no word expected, got data %h status %0d last %b",
                        $time, rsp_data_value, rsp_status, rsp_last);
            end else begin
               want = expected_words.pop_front();
               check_field("data_value", want.data_value, rsp_data_value);
               check_field("status", want.status, rsp_status);
               check_field("last", want.last, rsp_last);
               checked++;
            end
         end
      end
      error_count   <= errors;
      pending_count <= expected_words.size();
      words_checked <= checked;
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import dsa_pkg::*;

   // Action codes the block must ignore without a word.
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

   // Request mixes; the lean mixes push one side and pop the other, so one
   // stack climbs toward a full store.
   typedef enum int {
      MIX_BALANCED,
      MIX_FILL,
      MIX_DRAIN,
      MIX_LEAN_A,
      MIX_LEAN_B
   } op_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dsa_req_if req_bus();
   dsa_rsp_if rsp_bus();

   int send_idle_pct   = 27;
   int recv_idle_pct   = 84;
   int rsp_hold_cycles = 0;
   int push_words      = 0;
   int pop_words       = 0;
   int list_words      = 0;
   int unused_words    = 0;
   int error_count;
   int pending_count;
   int words_checked;

   always #4 clock = ~clock;

   dual_stack_shared_array_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   dsa_stack_checker stack_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_action     (req_bus.action),
      .req_push_value (req_bus.push_value),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_data_value (rsp_bus.data_value),
      .rsp_status     (rsp_bus.status),
      .rsp_last       (rsp_bus.last),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .words_checked  (words_checked)
   );

   // Receiver: hold ready low while a hold-off is counting down, otherwise
   // drop it at random by the current idle percentage.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Guard against a hung handshake.
   initial begin
      #4_000_000;
      $display("dual_stack_shared_array_unit: mismatch");
      $finish;
   end

   // Store corners: both signed extremes, zero and all ones.
   function automatic logic [DATA_W-1:0] edge_value(input int k);
      case (k)
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_push_value();
      int k;
      k = $urandom_range(0, 11);
      return (k < 4) ? edge_value(k) : $urandom;
   endfunction

   // Offer one request word, idling first at random, and hold it until accepted.
   task automatic send_word(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.push_value <= val;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      case (act)
         ACT_PUSH_A, ACT_PUSH_B: push_words++;
         ACT_POP_A, ACT_POP_B:   pop_words++;
         ACT_LIST_A, ACT_LIST_B: list_words++;
         default:                unused_words++;
      endcase
   endtask

   // Stop offering and wait until every predicted word has come back. The first
   // edge lets the checker register the word accepted on this edge.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   // Random requests; spare codes are sent now and then but do not count.
   task automatic run_random_words(input int n_words);
      op_mix_type                mix;
      int                        done;
      int                        k;
      int                        push_pct;
      int                        pop_pct;
      bit                        lean;
      bit                        lean_a;
      bit                        rare;
      bit                        side_b;
      logic [ACTION_W-1:0]       act;
      logic [DATA_W-1:0]         val;
      mix  = MIX_BALANCED;
      done = 0;
      while (done < n_words) begin
         // switch the mix every 32 words so counts wander from empty to full
         if (done % 32 == 0)
            mix = op_mix_type'($urandom_range(0, 4));
         case (mix)
            MIX_BALANCED: begin
               push_pct = 42;
               pop_pct  = 42;
            end
            MIX_FILL: begin
               push_pct = 75;
               pop_pct  = 10;
            end
            MIX_DRAIN: begin
               push_pct = 15;
               pop_pct  = 72;
            end
            default: begin
               push_pct = 55;
               pop_pct  = 30;
            end
         endcase
         lean   = (mix == MIX_LEAN_A) || (mix == MIX_LEAN_B);
         lean_a = (mix == MIX_LEAN_A);
         rare   = ($urandom_range(0, 9) == 0);
         val    = $urandom;
         k      = $urandom_range(0, 99);
         if (k < 2) begin
            send_word((k == 0) ? ACT_UNUSED_LO : ACT_UNUSED_HI, val);
         end else begin
            k = $urandom_range(0, 99);
            if (k < push_pct) begin
               side_b = lean ? (!lean_a ^ rare) : $urandom_range(0, 1);
               act    = side_b ? ACT_PUSH_B : ACT_PUSH_A;
               val    = random_push_value();
            end else if (k < push_pct + pop_pct) begin
               side_b = lean ? (lean_a ^ rare) : $urandom_range(0, 1);
               act    = side_b ? ACT_POP_B : ACT_POP_A;
            end else begin
               act = $urandom_range(0, 1) ? ACT_LIST_B : ACT_LIST_A;
            end
            send_word(act, val);
            done++;
         end
      end
   endtask

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ACT_PUSH_A;
      req_bus.push_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: underflow and empty list on fresh stacks, fill the store
      // alternating sides with corner values, refuse one push per side, then
      // list and pop both sides of a full store.
      send_word(ACT_POP_A, '0);
      send_word(ACT_POP_B, '0);
      send_word(ACT_LIST_A, '0);
      send_word(ACT_LIST_B, '0);
      for (int i = 0; i < DEPTH_DEFAULT; i++)
         send_word((i % 2 == 1) ? ACT_PUSH_B : ACT_PUSH_A, (i < 4) ? edge_value(i) : $urandom);
      send_word(ACT_PUSH_A, 32'h1234_5678);
      send_word(ACT_PUSH_B, 32'h8765_4321);
      send_word(ACT_LIST_A, '0);
      send_word(ACT_LIST_B, '0);
      send_word(ACT_POP_A, '0);
      send_word(ACT_POP_B, '0);
      drain_results();

      // Slow receiver.
      run_random_words(150);
      drain_results();

      // Slow sender.
      send_idle_pct = 84;
      recv_idle_pct = 27;
      run_random_words(150);
      drain_results();

      // Full rate; first hold the receiver off so the block backs up and stalls
      // its input while requests keep coming.
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      rsp_hold_cycles = 150;
      run_random_words(30);
      drain_results();
      run_random_words(130);
      drain_results();

      repeat (20) @(posedge clock);
      $display("Covered %0d pushes, %0d pops, %0d lists and %0d spare codes",
               push_words, pop_words, list_words, unused_words);
      $display("across idle mixes and a long receiver hold-off; %0d words checked",
               words_checked);
      if (error_count == 0 && pending_count == 0) begin
         $display("dual_stack_shared_array_unit: match");
      end else begin
         $display("dual_stack_shared_array_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/dsa_pkg.sv
design/dsa_req_if.sv
design/dsa_rsp_if.sv
design/dual_stack_shared_array_unit.sv
dv/dsa_stack_checker.sv
dv/tb_top.sv
